// ----- sv/attf_pkg.sv -----
// ---------------------------------------------------------------------------
// attf_pkg
// Shared widths, register indexes, item type and divider step functions.
// ---------------------------------------------------------------------------
package attf_pkg;

  localparam int FRAME_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 24;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 3;
  localparam int LATENCY    = 3 * DIV_W + FRAC_BITS + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_PERIOD   = 3'd0,
    REG_FIRST    = 3'd1,
    REG_COUNT    = 3'd2,
    REG_LOOPBACK = 3'd3,
    REG_LOOPLEN  = 3'd4,
    REG_LOOPEN   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]          time_ms;
    logic [DVS_W-1:0]     period;
    logic [DIV_W-1:0]     frame;
    logic [DVS_W-1:0]     rem;
    logic [FRAC_BITS-1:0] frac;
    logic                 x_neg;
  } item_t;

  typedef struct packed {
    logic [DVS_W-1:0] r;
    logic [DIV_W-1:0] q;
  } div_st_t;

  typedef struct packed {
    logic [DVS_W-1:0]     r;
    logic [FRAC_BITS-1:0] q;
  } frac_st_t;

  function automatic div_st_t div_step(logic [DVS_W-1:0] r, logic [DIV_W-1:0] q,
                                       logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic [DVS_W:0] diff;
    logic           ge;
    div_st_t        s;
    t      = {r, q[DIV_W-1]};
    diff   = t - {1'b0, d};
    ge     = (t >= {1'b0, d});
    s.r    = ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
    s.q    = {q[DIV_W-2:0], ge};
    return s;
  endfunction

  function automatic frac_st_t frac_step(logic [DVS_W-1:0] r, logic [FRAC_BITS-1:0] q,
                                         logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic [DVS_W:0] diff;
    logic           ge;
    frac_st_t       s;
    t      = {r, 1'b0};
    diff   = t - {1'b0, d};
    ge     = (t >= {1'b0, d});
    s.r    = ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
    s.q    = {q[FRAC_BITS-2:0], ge};
    return s;
  endfunction

endpackage

// ----- sv/anim_time_to_frame_top.sv -----
// ---------------------------------------------------------------------------
// anim_time_to_frame_top
// Maps a playback time to low/high frames, a blend fraction and a play flag.
// ---------------------------------------------------------------------------
// Usage:
//   Write the clip registers over the cfg channel (cfg_ready_o is always
//   high) while no item is in flight. Issue an item by raising start with
//   time_ms_i and forced_length_i; busy is always low, so an item may be
//   issued in every cycle. Each item yields one result on done_o for a
//   single cycle, in issue order. Sustained rate is one item per cycle.
//   Each item passes through a chain of bit-per-stage dividers: frame count
//   divider (32), time over period (32), blend fraction (16), loop modulo
//   (32), plus the output register.
//   Reset clears all valid bits, so items in flight are dropped, and loads
//   the registers with their documented reset values.
//   The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
module anim_time_to_frame_top import attf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           time_ms_i,
  input  logic [23:0]           forced_length_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output logic                  done_o,
  output logic [FRAME_BITS-1:0] low_frame_o,
  output logic [FRAME_BITS-1:0] high_frame_o,
  output logic [FRAC_BITS-1:0]  blend_fraction_o,
  output logic                  still_playing_o
);

  logic [CFG_W-1:0] period_q, first_q, count_q, loopback_q, looplen_q;
  logic             loopen_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= CFG_W'(33);
      first_q    <= '0;
      count_q    <= CFG_W'(1);
      loopback_q <= '0;
      looplen_q  <= CFG_W'(1);
      loopen_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PERIOD:   period_q   <= cfg_data_i;
        REG_FIRST:    first_q    <= cfg_data_i;
        REG_COUNT:    count_q    <= cfg_data_i;
        REG_LOOPBACK: loopback_q <= cfg_data_i;
        REG_LOOPLEN:  looplen_q  <= cfg_data_i;
        REG_LOOPEN:   loopen_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] llen;
  assign llen = (looplen_q == '0) ? CFG_W'(1) : looplen_q;

  // forced length over frame count
  item_t            it0, it1, it2, it3, it4, it5, it6;
  logic             v1, v3, v5, v6;
  logic [DIV_W-1:0] q1, q3, q5;
  logic [DVS_W-1:0] r1, r3, r5;
  logic [DIV_W-1:0] fl_q;

  always_comb begin
    it0         = '0;
    it0.time_ms = time_ms_i;
  end

  attf_div u_div_len (
    .clk_i, .rst_ni,
    .in_valid_i (start && !busy),
    .in_item_i  (it0),
    .dividend_i ({{(DIV_W-24){1'b0}}, forced_length_i}),
    .divisor_i  ((count_q == '0) ? DVS_W'(1) : DVS_W'(count_q)),
    .out_valid_o(v1),
    .out_item_o (it1),
    .quot_o     (q1),
    .rem_o      (r1)
  );

  // forced length rides in the low quotient bits? no: carry it alongside
  logic [23:0] fl_pipe [DIV_W];
  for (genvar k = 0; k < DIV_W; k++) begin : g_fl
    always_ff @(posedge clk_i) begin
      fl_pipe[k] <= (k == 0) ? forced_length_i : fl_pipe[(k == 0) ? 0 : k-1];
    end
  end
  assign fl_q = {{(DIV_W-24){1'b0}}, fl_pipe[DIV_W-1]};

  logic [DVS_W-1:0] per_sel;
  always_comb begin
    per_sel = (fl_q != '0) ? q1[DVS_W-1:0] : DVS_W'(period_q);
    if (per_sel == '0) begin
      per_sel = DVS_W'(1);
    end
    it2        = it1;
    it2.period = per_sel;
  end

  // time over period
  attf_div u_div_time (
    .clk_i, .rst_ni,
    .in_valid_i (v1),
    .in_item_i  (it2),
    .dividend_i ({1'b0, it2.time_ms[30:0]}),
    .divisor_i  (it2.period),
    .out_valid_o(v3),
    .out_item_o (it3),
    .quot_o     (q3),
    .rem_o      (r3)
  );

  item_t it3m;
  logic  v4;
  always_comb begin
    it3m       = it3;
    it3m.frame = q3;
    it3m.rem   = r3;
  end

  attf_frac u_frac (
    .clk_i, .rst_ni,
    .in_valid_i (v3),
    .in_item_i  (it3m),
    .out_valid_o(v4),
    .out_item_o (it4)
  );

  // loop offset: frame - loopback + first, signed
  logic signed [DIV_W+1:0] x;
  logic        [DIV_W+1:0] ax;
  item_t                   it4m;
  always_comb begin
    x  = $signed({2'b00, it4.frame}) - $signed({{(DIV_W+2-CFG_W){1'b0}}, loopback_q})
       + $signed({{(DIV_W+2-CFG_W){1'b0}}, first_q});
    ax = x[DIV_W+1] ? -x : x;
    it4m       = it4;
    it4m.x_neg = x[DIV_W+1];
  end

  attf_div u_div_loop (
    .clk_i, .rst_ni,
    .in_valid_i (v4),
    .in_item_i  (it4m),
    .dividend_i (ax[DIV_W-1:0]),
    .divisor_i  (DVS_W'(llen)),
    .out_valid_o(v5),
    .out_item_o (it5),
    .quot_o     (q5),
    .rem_o      (r5)
  );

  // final select
  logic                  done_q;
  logic [FRAME_BITS-1:0] low_q, high_q;
  logic [FRAC_BITS-1:0]  frac_q;
  logic                  play_q;
  logic [FRAME_BITS-1:0] low_d, high_d;
  logic [FRAC_BITS-1:0]  frac_d;
  logic                  play_d;
  logic                  past_end;
  logic [CFG_W:0]        ra, ra_n;
  logic [FRAME_BITS-1:0] last;

  assign it6 = it5;
  assign v6  = v5;

  always_comb begin
    past_end = $signed({1'b0, it6.frame}) >= ($signed({{(DIV_W-CFG_W+1){1'b0}}, count_q})
             - $signed((DIV_W+1)'(1)));
    ra       = {1'b0, r5[CFG_W-1:0]};
    last     = FRAME_BITS'(first_q) + FRAME_BITS'(count_q) - FRAME_BITS'(1);
    low_d    = FRAME_BITS'(first_q) + it6.frame[FRAME_BITS-1:0];
    high_d   = low_d + FRAME_BITS'(1);
    frac_d   = it6.frac;
    play_d   = 1'b1;
    ra_n     = '0;
    if (it6.time_ms[31]) begin
      low_d  = '0;
      high_d = FRAME_BITS'(1);
      frac_d = '0;
    end else if (past_end && !loopen_q) begin
      low_d  = last;
      high_d = last;
      frac_d = '0;
      play_d = 1'b0;
    end else if (past_end) begin
      if (it6.x_neg) begin
        ra_n   = (ra == '0) ? ({1'b0, llen} - (CFG_W+1)'(1)) : (ra - (CFG_W+1)'(1));
        low_d  = FRAME_BITS'(loopback_q) - FRAME_BITS'(ra);
        high_d = FRAME_BITS'(loopback_q) - FRAME_BITS'(ra_n);
      end else begin
        ra_n   = ((ra + (CFG_W+1)'(1)) == {1'b0, llen}) ? '0 : (ra + (CFG_W+1)'(1));
        low_d  = FRAME_BITS'(loopback_q) + FRAME_BITS'(ra);
        high_d = FRAME_BITS'(loopback_q) + FRAME_BITS'(ra_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    frac_q <= frac_d;
    play_q <= play_d;
  end

  assign done_o           = done_q;
  assign low_frame_o      = low_q;
  assign high_frame_o     = high_q;
  assign blend_fraction_o = frac_q;
  assign still_playing_o  = play_q;

  logic unused_ok;
  assign unused_ok = ^{r1, q1[DIV_W-1:DVS_W], q5[DIV_W-1:0]};

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

  a_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !still_playing_o) |-> (low_frame_o == high_frame_o && blend_fraction_o == '0))
    else $error("frozen result not on one frame");

  a_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1 |-> (it2.period != '0))
    else $error("zero period reached divider");

endmodule

// ----- sv/attf_div.sv -----
// ---------------------------------------------------------------------------
// attf_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module attf_div import attf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  item_t            in_item_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             out_valid_o,
  output item_t            out_item_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  logic             v_q [DIV_W];
  item_t            it_q [DIV_W];
  logic [DIV_W-1:0] q_q [DIV_W];
  logic [DVS_W-1:0] r_q [DIV_W];
  logic [DVS_W-1:0] d_q [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_st
    logic             v_d;
    item_t            it_d;
    logic [DIV_W-1:0] q_in;
    logic [DVS_W-1:0] r_in;
    logic [DVS_W-1:0] d_d;
    div_st_t          s;
    if (k == 0) begin : g_first
      assign v_d  = in_valid_i;
      assign it_d = in_item_i;
      assign q_in = dividend_i;
      assign r_in = '0;
      assign d_d  = divisor_i;
    end else begin : g_next
      assign v_d  = v_q[k-1];
      assign it_d = it_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign d_d  = d_q[k-1];
    end
    assign s = div_step(r_in, q_in, d_d);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k] <= it_d;
      q_q[k]  <= s.q;
      r_q[k]  <= s.r;
      d_q[k]  <= d_d;
    end
  end

  assign out_valid_o = v_q[DIV_W-1];
  assign out_item_o  = it_q[DIV_W-1];
  assign quot_o      = q_q[DIV_W-1];
  assign rem_o       = r_q[DIV_W-1];

endmodule

// ----- sv/attf_frac.sv -----
// ---------------------------------------------------------------------------
// attf_frac
// Pipelined fraction divider: remainder over period as a 0.FRAC_BITS value.
// ---------------------------------------------------------------------------
module attf_frac import attf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  out_valid_o,
  output item_t out_item_o
);

  logic                 v_q [FRAC_BITS];
  item_t                it_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] q_q [FRAC_BITS];
  logic [DVS_W-1:0]     r_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_st
    logic                 v_d;
    item_t                it_d;
    logic [FRAC_BITS-1:0] q_in;
    logic [DVS_W-1:0]     r_in;
    frac_st_t             s;
    if (k == 0) begin : g_first
      assign v_d  = in_valid_i;
      assign it_d = in_item_i;
      assign q_in = '0;
      assign r_in = in_item_i.rem;
    end else begin : g_next
      assign v_d  = v_q[k-1];
      assign it_d = it_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign s = frac_step(r_in, q_in, it_d.period);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k] <= it_d;
      q_q[k]  <= s.q;
      r_q[k]  <= s.r;
    end
  end

  always_comb begin
    out_item_o      = it_q[FRAC_BITS-1];
    out_item_o.frac = q_q[FRAC_BITS-1];
  end
  assign out_valid_o = v_q[FRAC_BITS-1];

endmodule

// ----- verif/tb_anim_time_to_frame_top.sv -----
// ---------------------------------------------------------------------------
// tb_anim_time_to_frame_top
// Self-checking bench for the time-to-frame mapper: directed rows from a
// table, then random items with random gaps over several clip settings.
// Every result is compared against an in-bench frame predictor.
// ---------------------------------------------------------------------------
module tb_anim_time_to_frame_top;
  import attf_pkg::*;

  typedef struct packed {
    logic [FRAME_BITS-1:0] low;
    logic [FRAME_BITS-1:0] high;
    logic [FRAC_BITS-1:0]  frac;
    logic                  playing;
  } frame_res_t;

  typedef struct {
    logic [31:0] t;
    logic [23:0] forced;
    bit          typed;
    frame_res_t  res;
  } stim_row_t;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  start = 0;
  logic                  busy;
  logic [31:0]           time_ms_i = '0;
  logic [23:0]           forced_length_i = '0;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  done_o;
  logic [FRAME_BITS-1:0] low_frame_o;
  logic [FRAME_BITS-1:0] high_frame_o;
  logic [FRAC_BITS-1:0]  blend_fraction_o;
  logic                  still_playing_o;

  logic [15:0] clip_period, clip_first, clip_count, clip_loopback, clip_looplen;
  logic        clip_loop;
  frame_res_t  pending_frames[$];
  stim_row_t   rows[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_loop = 0;
  int          n_frozen = 0;

  always #2 clk_i = ~clk_i;

  anim_time_to_frame_top u_dut (.*);

  function automatic frame_res_t predict_frames(logic [31:0] t, logic [23:0] forced);
    frame_res_t r;
    longint unsigned per, fr, rm;
    longint fc, first, off, llen, lo, hi, lb;
    per = clip_period;
    if (forced != 0) per = forced / ((clip_count != 0) ? clip_count : 1);
    if (per == 0) per = 1;
    if (t[31]) begin
      r.low = 0; r.high = 1; r.frac = 0; r.playing = 1;
      return r;
    end
    fr = t / per;
    rm = t - fr * per;
    fc = clip_count;
    first = clip_first;
    lb = longint'(clip_loopback);
    if (longint'(fr) >= fc - 1) begin
      if (!clip_loop) begin
        r.low = FRAME_BITS'(first + fc - 1);
        r.high = r.low; r.frac = 0; r.playing = 0;
        return r;
      end
      off = lb - first;
      llen = (clip_looplen != 0) ? clip_looplen : 1;
      lo = ((longint'(fr) - off) % llen) + lb;
      hi = ((longint'(fr) - off + 1) % llen) + lb;
    end else begin
      lo = (longint'(fr) % fc) + first;
      hi = ((longint'(fr) + 1) % fc) + first;
    end
    r.low = FRAME_BITS'(lo);
    r.high = FRAME_BITS'(hi);
    r.frac = FRAC_BITS'((rm << FRAC_BITS) / per);
    r.playing = 1;
    return r;
  endfunction

  function automatic void add_row(logic [31:0] t, logic [23:0] forced, bit typed,
                                  frame_res_t res);
    stim_row_t r;
    r.t = t;
    r.forced = forced;
    r.typed = typed;
    r.res = res;
    rows = {rows, r};
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    case (idx)
      REG_PERIOD:   clip_period = val;
      REG_FIRST:    clip_first = val;
      REG_COUNT:    clip_count = val;
      REG_LOOPBACK: clip_loopback = val;
      REG_LOOPLEN:  clip_looplen = val;
      REG_LOOPEN:   clip_loop = val[0];
      default: ;
    endcase
  endtask

  task automatic set_clip(logic [15:0] p, logic [15:0] f, logic [15:0] c,
                          logic [15:0] lb, logic [15:0] ll, logic le);
    write_reg(REG_PERIOD, p); write_reg(REG_FIRST, f); write_reg(REG_COUNT, c);
    write_reg(REG_LOOPBACK, lb); write_reg(REG_LOOPLEN, ll);
    write_reg(REG_LOOPEN, {15'd0, le});
  endtask

  task automatic drain;
    while (pending_frames.size() != 0) @(negedge clk_i);
  endtask

  task automatic issue(logic [31:0] t, logic [23:0] forced, bit typed, frame_res_t res);
    frame_res_t p;
    p = predict_frames(t, forced);
    if (typed && p != res) begin
      $error("typed row disagrees with predictor for time %0d", $signed(t));
      errors++;
    end
    start <= 1; time_ms_i <= t; forced_length_i <= forced;
    do @(posedge clk_i); while (busy);
    pending_frames = {pending_frames, (typed ? res : p)};
    if (p.playing == 0) n_frozen++;
    else if (clip_loop) n_loop++;
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap;
    int g;
    g = $urandom_range(0, 99);
    if (g < 50) g = 0;
    else if (g < 93) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g != 0) start <= 0;
    repeat (g) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_time(int span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b1, 31'($urandom())};
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  always @(posedge clk_i) begin
    frame_res_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_frames.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = pending_frames.pop_front();
        if (low_frame_o !== e.low) begin
          $error("low_frame exp %0d got %0d", e.low, low_frame_o); errors++;
        end
        if (high_frame_o !== e.high) begin
          $error("high_frame exp %0d got %0d", e.high, high_frame_o); errors++;
        end
        if (blend_fraction_o !== e.frac) begin
          $error("blend_fraction exp %0d got %0d", e.frac, blend_fraction_o); errors++;
        end
        if (still_playing_o !== e.playing) begin
          $error("still_playing exp %0d got %0d", e.playing, still_playing_o); errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    frame_res_t nr;
    int span;
    clip_period = 33; clip_first = 0; clip_count = 1;
    clip_loopback = 0; clip_looplen = 1; clip_loop = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // reset values: one-frame clip, frozen at frame 0 for non-negative times
    add_row(32'd0, 24'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0});
    add_row(32'h7fff_ffff, 24'hff_ffff, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0});
    add_row(32'h8000_0000, 24'd0, 1'b1, '{16'd0, 16'd1, 16'd0, 1'b1});
    add_row(32'hffff_ffff, 24'hff_ffff, 1'b1, '{16'd0, 16'd1, 16'd0, 1'b1});
    foreach (rows[i]) issue(rows[i].t, rows[i].forced, rows[i].typed, rows[i].res);
    start <= 0;
    drain();

    // loop back beyond the clip end, first frame wraps, tiny periods
    set_clip(16'd10, 16'hfffe, 16'd20, 16'd40, 16'd0, 1'b1);
    rows.delete();
    add_row(32'd0, 24'd0, 1'b0, nr);
    add_row(32'd15, 24'd0, 1'b0, nr);
    add_row(32'd185, 24'd0, 1'b0, nr);
    add_row(32'd190, 24'd0, 1'b0, nr);
    add_row(32'd5000, 24'd0, 1'b0, nr);
    add_row(32'd77, 24'd5, 1'b0, nr);
    add_row(32'd77, 24'd400, 1'b0, nr);
    add_row(32'h7fff_ffff, 24'd1, 1'b0, nr);
    add_row(32'h5555_aaaa, 24'haa_5555, 1'b0, nr);
    foreach (rows[i]) issue(rows[i].t, rows[i].forced, rows[i].typed, rows[i].res);
    start <= 0;
    drain();

    // zero frame count and zero period
    set_clip(16'd0, 16'd3, 16'd0, 16'd1, 16'hffff, 1'b0);
    rows.delete();
    add_row(32'd0, 24'd0, 1'b1, '{16'd2, 16'd2, 16'd0, 1'b0});
    add_row(32'd9, 24'd7, 1'b1, '{16'd2, 16'd2, 16'd0, 1'b0});
    foreach (rows[i]) issue(rows[i].t, rows[i].forced, rows[i].typed, rows[i].res);
    start <= 0;
    drain();
    write_reg(REG_LOOPEN, 16'd1);
    issue(32'd9, 24'd0, 1'b0, nr);
    issue(32'd70000, 24'd0, 1'b0, nr);
    start <= 0;
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      repeat (LATENCY) @(negedge clk_i);
      case (ph)
        0: set_clip(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
        1: set_clip(16'd1, 16'd0, 16'd2, 16'd0, 16'd1, 1'b0);
        default: set_clip(16'($urandom_range(1, 200)), 16'($urandom()),
                          16'($urandom_range(0, 300)), 16'($urandom()),
                          16'($urandom_range(0, 300)), 1'($urandom_range(0, 1)));
      endcase
      span = (clip_period + 1) * (clip_count + 2) * 2;
      for (int k = 0; k < 120; k++) begin
        issue(rand_time(span), ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 4) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 3000)))
              : 24'd0, 1'b0, nr);
        if (k == 60) begin
          start <= 0;
          drain();
        end
        if (ph % 3 != 1) idle_gap();
      end
      start <= 0;
      drain();
    end

    repeat (LATENCY + 20) @(negedge clk_i);
    $display("covered %0d items, %0d results: %0d looping, %0d frozen at clip end",
             n_items, n_results, n_loop, n_frozen);
    if (errors == 0 && pending_frames.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/attf_pkg.sv
sv/attf_div.sv
sv/attf_frac.sv
sv/anim_time_to_frame_top.sv
verif/tb_anim_time_to_frame_top.sv
